// File: src/sgma_pkg.sv
// ----------------------------------------------------------------------------
// sgma_pkg: shared types and constants
// sobel gradient magnitude and angle, cordic table and request/reply types, no operation codes
// ----------------------------------------------------------------------------
package sgma_pkg;

  localparam int CordicSteps = 16;
  localparam int IterBits    = 4;
  // quarter turn in pseudo-degrees, q.16
  localparam logic signed [24:0] QuarterTurn = 25'sd5898245;

  // cordic x/y width: |g|*256*~1.65 fits in 20 bits signed plus margin
  localparam int CordW = 22;
  localparam int AngW  = 25;

  typedef logic signed [10:0] grad_t;

  function automatic logic signed [AngW-1:0] atan_entry(input logic [IterBits-1:0] i);
    logic signed [AngW-1:0] v;
    case (i)
      4'd0:  v = 25'sd2949122;
      4'd1:  v = 25'sd1740969;
      4'd2:  v = 25'sd919880;
      4'd3:  v = 25'sd466945;
      4'd4:  v = 25'sd234379;
      4'd5:  v = 25'sd117304;
      4'd6:  v = 25'sd58666;
      4'd7:  v = 25'sd29335;
      4'd8:  v = 25'sd14668;
      4'd9:  v = 25'sd7334;
      4'd10: v = 25'sd3667;
      4'd11: v = 25'sd1833;
      4'd12: v = 25'sd917;
      4'd13: v = 25'sd458;
      4'd14: v = 25'sd229;
      4'd15: v = 25'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

  // request and reply between the top level and the shared unit
  typedef struct packed {
    logic  start;
    grad_t gx;
    grad_t gy;
  } sgma_req_t;

  typedef struct packed {
    logic             done;
    logic [7:0]       mag;
    logic signed [8:0] ang;
  } sgma_rsp_t;

endpackage

// File: src/sobel_gradient_magnitude_angle.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_angle: 3x3 sobel gradient, magnitude and angle
// sliding column window with a shared iterative magnitude/angle unit
// ----------------------------------------------------------------------------
// channel | direction | payload
// in_     | input     | top/mid/bottom pixel, row_start, row_end
// out_    | output    | grad_x, grad_y, magnitude, angle_deg, last
//
// each result is computed in the shared cordic/square-root unit
// (sixteen iterations plus load and finish); an item gives no, one or two
// results, and no new input is taken until all of them have been accepted
// input is taken only when idle; the result register holds while out_ready low
// rst_n synchronous active low clears the window and the sequencer
module sobel_gradient_magnitude_angle import sgma_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_top_pixel,
  input  logic [7:0]        in_mid_pixel,
  input  logic [7:0]        in_bottom_pixel,
  input  logic              in_row_start,
  input  logic              in_row_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [10:0] out_grad_x,
  output logic signed [10:0] out_grad_y,
  output logic [7:0]        out_magnitude,
  output logic signed [8:0] out_angle_deg,
  output logic              out_last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,  // waiting for a transaction
    S_CALC = 4'b0010,  // shared unit busy
    S_OUT  = 4'b0100,  // result waiting to be taken
    S_NEXT = 4'b1000   // launching a calc on the current window
  } state_t;

  state_t state_r, state_nxt;
  logic [23:0] left_r, left_nxt, centre_r, centre_nxt, col_r, col_nxt;
  logic        cvalid_r, cvalid_nxt;
  logic        end_r, end_nxt;     // flush still owed
  logic        last_r, last_nxt;   // result under work is the flush
  grad_t       gx_r, gx_nxt, gy_r, gy_nxt;
  logic [7:0]  mag_r, mag_nxt;
  logic signed [8:0] ang_r, ang_nxt;

  sgma_req_t req;
  sgma_rsp_t rsp;

  // window for the next calc: left, centre, right
  logic [23:0] wl, wc, wr;
  grad_t gx_c, gy_c;

  function automatic logic [10:0] wsum(input logic [23:0] c);
    return 11'(c[23:16]) + 11'({c[15:8], 1'b0}) + 11'(c[7:0]);
  endfunction

  sgma_unit u_unit (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  always_comb begin
    wl = left_r;
    wc = centre_r;
    wr = last_r ? 24'd0 : col_r;
    gx_c = grad_t'(wsum(wr)) - grad_t'(wsum(wl));
    gy_c = grad_t'(11'(wl[23:16]) + 11'({wc[23:16], 1'b0}) + 11'(wr[23:16]))
         - grad_t'(11'(wl[7:0]) + 11'({wc[7:0], 1'b0}) + 11'(wr[7:0]));
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    left_nxt = left_r; centre_nxt = centre_r; col_nxt = col_r;
    cvalid_nxt = cvalid_r; end_nxt = end_r; last_nxt = last_r;
    gx_nxt = gx_r; gy_nxt = gy_r; mag_nxt = mag_r; ang_nxt = ang_r;
    req.start = 1'b0;
    req.gx = gx_c;
    req.gy = gy_c;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          col_nxt = {in_top_pixel, in_mid_pixel, in_bottom_pixel};
          end_nxt = in_row_end;
          if (in_row_start) begin
            left_nxt = '0;
          end
          if (cvalid_r && !in_row_start) begin
            last_nxt = 1'b0;
            state_nxt = S_NEXT;
          end else begin
            // no pending centre, or a row start drops it: new column goes straight in
            centre_nxt = {in_top_pixel, in_mid_pixel, in_bottom_pixel};
            cvalid_nxt = 1'b1;
            if (in_row_end) begin
              last_nxt = 1'b1;
              end_nxt = 1'b0;
              state_nxt = S_NEXT;
            end
          end
        end
      end
      S_NEXT: begin
        // launch the calc on the current window
        req.start = 1'b1;
        gx_nxt = gx_c;
        gy_nxt = gy_c;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        if (rsp.done) begin
          mag_nxt = rsp.mag;
          ang_nxt = rsp.ang;
          state_nxt = S_OUT;
          if (last_r) begin
            left_nxt = '0; centre_nxt = '0; cvalid_nxt = 1'b0;
          end else begin
            // slide the window
            left_nxt = centre_r;
            centre_nxt = col_r;
            cvalid_nxt = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (end_r) begin
            end_nxt = 1'b0;
            last_nxt = 1'b1;
            state_nxt = S_NEXT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      left_r   <= '0;
      centre_r <= '0;
      cvalid_r <= 1'b0;
      end_r    <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      left_r   <= left_nxt;
      centre_r <= centre_nxt;
      cvalid_r <= cvalid_nxt;
      end_r    <= end_nxt;
      last_r   <= last_nxt;
    end
    col_r <= col_nxt;
    gx_r  <= gx_nxt;
    gy_r  <= gy_nxt;
    mag_r <= mag_nxt;
    ang_r <= ang_nxt;
  end

  assign out_valid     = (state_r == S_OUT);
  assign out_grad_x    = gx_r;
  assign out_grad_y    = gy_r;
  assign out_magnitude = mag_r;
  assign out_angle_deg = ang_r;
  assign out_last      = last_r;

endmodule

// File: src/sgma_unit.sv
// ----------------------------------------------------------------------------
// sgma_unit: magnitude and angle of one gradient vector
// one shared cordic/square-root step per cycle, sixteen iterations
// ----------------------------------------------------------------------------
module sgma_unit import sgma_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sgma_req_t req,
  output sgma_rsp_t rsp
);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_RUN  = 3'b010,
    U_DONE = 3'b100
  } ustate_t;

  ustate_t state_r, state_nxt;
  logic [IterBits-1:0] it_r, it_nxt;
  logic signed [CordW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [AngW-1:0]  z_r, z_nxt;
  logic [7:0]  root_r, root_nxt;
  logic [16:0] sum_r, sum_nxt;
  logic        sat_r, sat_nxt;
  logic        spec_r, spec_nxt;
  logic signed [8:0] spec_ang_r, spec_ang_nxt;

  logic signed [CordW-1:0] dx, dy, gx_s, gy_s;
  logic signed [10:0] ax, ay;
  logic [21:0] sq_sum;
  logic [7:0]  trial;
  logic [15:0] trial_sq;
  logic signed [AngW-1:0] zabs, res_full;
  logic signed [8:0] res_ang;

  always_comb begin
    ax = req.gx[10] ? -req.gx : req.gx;
    ay = req.gy[10] ? -req.gy : req.gy;
    sq_sum = 22'(unsigned'(ax) * unsigned'(ax)) + 22'(unsigned'(ay) * unsigned'(ay));
    gx_s = CordW'(req.gx) <<< 8;
    gy_s = CordW'(req.gy) <<< 8;
    dx = y_r >>> it_r;
    dy = x_r >>> it_r;
    // square root: one result bit per iteration over the first eight, msb first
    trial = root_r | (8'd128 >> it_r[2:0]);
    trial_sq = trial * trial;
    zabs = z_r[AngW-1] ? -z_r : z_r;
    res_full = z_r[AngW-1] ? -(zabs >>> 16) : (zabs >>> 16);
    if (res_full > 180)       res_ang = 9'sd180;
    else if (res_full < -180) res_ang = -9'sd180;
    else                      res_ang = res_full[8:0];
  end

  always_comb begin
    state_nxt = state_r;
    it_nxt = it_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    root_nxt = root_r; sum_nxt = sum_r; sat_nxt = sat_r;
    spec_nxt = spec_r; spec_ang_nxt = spec_ang_r;
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          state_nxt = U_RUN;
          it_nxt = '0;
          root_nxt = '0;
          sat_nxt = (sq_sum >= 22'd65025);
          sum_nxt = sq_sum[16:0];
          spec_nxt = 1'b1;
          x_nxt = gx_s; y_nxt = gy_s; z_nxt = '0;
          if (req.gy == 0)      spec_ang_nxt = req.gx[10] ? 9'sd180 : 9'sd0;
          else if (req.gx == 0) spec_ang_nxt = req.gy[10] ? -9'sd90 : 9'sd90;
          else if (ax == ay) begin
            if (!req.gx[10]) spec_ang_nxt = req.gy[10] ? -9'sd45 : 9'sd45;
            else             spec_ang_nxt = req.gy[10] ? -9'sd135 : 9'sd135;
          end else begin
            spec_nxt = 1'b0;
            spec_ang_nxt = '0;
            // left half-plane: quarter turn first
            if (req.gx[10]) begin
              if (!req.gy[10]) begin
                x_nxt = gy_s; y_nxt = -gx_s; z_nxt = QuarterTurn;
              end else begin
                x_nxt = -gy_s; y_nxt = gx_s; z_nxt = -QuarterTurn;
              end
            end
          end
        end
      end
      U_RUN: begin
        if (!y_r[CordW-1]) begin
          x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + atan_entry(it_r);
        end else begin
          x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - atan_entry(it_r);
        end
        if (!it_r[3] && {1'b0, trial_sq} <= sum_r) root_nxt = trial;
        it_nxt = it_r + 1'b1;
        if (it_r == IterBits'(CordicSteps - 1)) state_nxt = U_DONE;
      end
      U_DONE: state_nxt = U_IDLE;
      default: state_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    it_r <= it_nxt;
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    root_r <= root_nxt; sum_r <= sum_nxt; sat_r <= sat_nxt;
    spec_r <= spec_nxt; spec_ang_r <= spec_ang_nxt;
  end

  assign rsp.done = (state_r == U_DONE);
  assign rsp.mag  = sat_r ? 8'd255 : root_r;
  assign rsp.ang  = spec_r ? spec_ang_r : res_ang;

endmodule

// File: tb/tb_sobel_gradient_magnitude_angle.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sobel_gradient_magnitude_angle: self-checking bench for the sobel block
// drives pixel columns with row marks, predicts gradient, magnitude and angle
// per window and compares every result transaction in order
// ----------------------------------------------------------------------------
module tb_sobel_gradient_magnitude_angle import sgma_pkg::*; ();

  // cordic arctangent table in q.16 pseudo-degrees
  localparam longint AtanQ16 [16] = '{
    2949122, 1740969, 919880, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };
  localparam longint QuarterQ16 = 5898245;

  typedef struct packed {
    grad_t             gx;
    grad_t             gy;
    logic [7:0]        mag;
    logic signed [8:0] ang;
    logic              last;
  } sobel_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_top_pixel = '0;
  logic [7:0] in_mid_pixel = '0;
  logic [7:0] in_bottom_pixel = '0;
  logic in_row_start = 1'b0;
  logic in_row_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [10:0] out_grad_x;
  logic signed [10:0] out_grad_y;
  logic [7:0] out_magnitude;
  logic signed [8:0] out_angle_deg;
  logic out_last;

  // sliding window copy; columns packed top, mid, bottom
  logic [23:0] win_left = '0;
  logic [23:0] win_centre = '0;
  logic        win_centre_ok = 1'b0;

  sobel_res_t gradient_q[$];
  int mismatches = 0;
  int finished_ok = 0;

  always #5 clk = ~clk;

  sobel_gradient_magnitude_angle DUT (.*);

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int isqrt_sat(int gx, int gy);
    int sum;
    int r;
    int t;
    sum = gx * gx + gy * gy;
    if (sum >= 65025) return 255;
    r = 0;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = r + b;
      if (t * t <= sum) r = t;
    end
    return r;
  endfunction

  function automatic int cordic_angle(int gx, int gy);
    longint x;
    longint y;
    longint z;
    longint t;
    longint dx;
    longint dy;
    longint res;
    // axes and exact diagonals are settled before the iterations
    if (gy == 0) return (gx < 0) ? 180 : 0;
    if (gx == 0) return (gy > 0) ? 90 : -90;
    if (gx == gy || gx == -gy) begin
      if (gx > 0) return (gy > 0) ? 45 : -45;
      return (gy > 0) ? 135 : -135;
    end
    x = longint'(gx) * 256;
    y = longint'(gy) * 256;
    z = 0;
    // left half-plane: pre-rotate by a quarter turn
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = QuarterQ16;
      end else begin
        x = -y; y = t; z = -QuarterQ16;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += AtanQ16[i];
      end else begin
        x -= dx; y += dy; z -= AtanQ16[i];
      end
    end
    // truncate toward zero
    res = (z >= 0) ? (z >>> 16) : -((-z) >>> 16);
    if (res > 180) res = 180;
    if (res < -180) res = -180;
    return int'(res);
  endfunction

  function automatic sobel_res_t window_result(logic [23:0] l, logic [23:0] c,
                                               logic [23:0] r, logic lst);
    sobel_res_t o;
    int gx;
    int gy;
    gx = (r[23:16] + 2 * r[15:8] + r[7:0]) - (l[23:16] + 2 * l[15:8] + l[7:0]);
    gy = (l[23:16] + 2 * c[23:16] + r[23:16]) - (l[7:0] + 2 * c[7:0] + r[7:0]);
    o.gx = grad_t'(gx);
    o.gy = grad_t'(gy);
    o.mag = 8'(isqrt_sat(gx, gy));
    o.ang = 9'(cordic_angle(gx, gy));
    o.last = lst;
    return o;
  endfunction

  // advance the window by one accepted column
  task automatic predict_column(logic [23:0] col, logic rs, logic re);
    if (rs) begin
      win_left = '0;
      win_centre_ok = 1'b0;
    end
    if (win_centre_ok) begin
      gradient_q.push_back(window_result(win_left, win_centre, col, 1'b0));
      win_left = win_centre;
    end
    win_centre = col;
    win_centre_ok = 1'b1;
    if (re) begin
      gradient_q.push_back(window_result(win_left, win_centre, '0, 1'b1));
      win_left = '0;
      win_centre = '0;
      win_centre_ok = 1'b0;
    end
  endtask

  // one input transaction, random gap first unless gaps are off
  bit no_gaps = 0;
  task automatic send_column(logic [7:0] t, logic [7:0] m, logic [7:0] b,
                             logic rs, logic re);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_top_pixel <= t;
    in_mid_pixel <= m;
    in_bottom_pixel <= b;
    in_row_start <= rs;
    in_row_end <= re;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_column({t, m, b}, rs, re);
  endtask

  // result side: random stall per transaction, stretches with none
  bit no_stall = 0;
  initial begin
    int hold;
    sobel_res_t got;
    sobel_res_t exp_r;
    @(posedge rst_n);
    forever begin
      hold = no_stall ? 0 : $urandom_range(0, 9);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = '{out_grad_x, out_grad_y, out_magnitude, out_angle_deg, out_last};
      if (gradient_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        exp_r = gradient_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch gx %0d/%0d gy %0d/%0d mag %0d/%0d ang %0d/%0d last %0b/%0b",
                     exp_r.gx, got.gx, exp_r.gy, got.gy, exp_r.mag, got.mag,
                     exp_r.ang, got.ang, exp_r.last, got.last);
        end
      end
    end
  end

  // gradient vector cases: axes, diagonals, zero, saturation
  task automatic test_special_vectors();
    send_column(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);         // zero, single column
    send_column(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);   // flat full column, zero gradient
    send_column(8'd255, 8'd0, 8'd0, 1'b1, 1'b1);       // vertical axis up
    send_column(8'd0, 8'd0, 8'd255, 1'b1, 1'b1);       // vertical axis down
    send_column(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);         // horizontal: step edge
    send_column(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_column(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
    send_column(8'd255, 8'd0, 8'd0, 1'b1, 1'b0);       // diagonal corners
    send_column(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    send_column(8'd0, 8'd0, 8'd255, 1'b1, 1'b0);
    send_column(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    send_column(8'd170, 8'd85, 8'd1, 1'b1, 1'b0);      // full-scale mixed
    send_column(8'd3, 8'd200, 8'd254, 1'b0, 1'b1);
  endtask

  // row start while a centre is pending, and rows with no start mark
  task automatic test_row_marks();
    send_column(8'd10, 8'd20, 8'd30, 1'b1, 1'b0);
    send_column(8'd40, 8'd50, 8'd60, 1'b0, 1'b0);
    send_column(8'd90, 8'd5, 8'd77, 1'b1, 1'b0);       // drops pending centre
    send_column(8'd1, 8'd2, 8'd3, 1'b0, 1'b1);
    send_column(8'd200, 8'd100, 8'd50, 1'b0, 1'b0);    // no start after end
    send_column(8'd7, 8'd8, 8'd9, 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed rows of random width, some broken marks
  task automatic test_random_rows(int n_items);
    int sent;
    int width;
    sent = 0;
    while (sent < n_items) begin
      width = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
      if ($urandom_range(0, 7) == 0) no_stall = ~no_stall;
      for (int i = 0; i < width; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_column(rand_pixel(), rand_pixel(), rand_pixel(),
                      1'($urandom), 1'($urandom));
        else
          send_column(rand_pixel(), rand_pixel(), rand_pixel(),
                      i == 0, i == width - 1);
        sent++;
      end
    end
    no_gaps = 0;
    no_stall = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_vectors();
    test_row_marks();
    test_random_rows(1050);
    in_valid <= 1'b0;
    while (gradient_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    finished_ok = 1;
    if (mismatches == 0 && gradient_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // worst case ~1100 items with two results each and the longest gaps and stalls, taken ~10x over
  initial begin
    #12000000;
    if (!finished_ok) $display("Some tests failed");
    $finish;
  end

endmodule

// File: sobel_gradient_magnitude_angle.f
src/sgma_pkg.sv
src/sgma_unit.sv
src/sobel_gradient_magnitude_angle.sv
tb/tb_sobel_gradient_magnitude_angle.sv
